@@ hdl/prh_pkg.sv @@
// ----------------------------------------------------------------------------
// prh_pkg
// Types and constants shared by the per-host round trip statistics block.
// ----------------------------------------------------------------------------
package prh_pkg;

  localparam logic [23:0] RTT_ONES  = 24'hFF_FFFF;
  localparam logic [39:0] SUM_ONES  = 40'hFF_FFFF_FFFF;
  localparam logic [27:0] JACC_ONES = 28'hFFF_FFFF;
  localparam int          DIV_STEPS = 40;

  typedef enum logic [1:0] {
    KIND_PROBE = 2'd0,
    KIND_REPLY = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_OTHER = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    LINK_WAIT = 2'd0,
    LINK_UP   = 2'd1,
    LINK_DOWN = 2'd2
  } link_t;

  typedef enum logic [1:0] {
    CL_PROBE,
    CL_REPLY,
    CL_QUERY,
    CL_OOR
  } class_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPD,
    ST_WRITE,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    REG_MAX_PROBES = 2'd0,
    REG_DOWN_AFTER = 2'd1,
    REG_INFLIGHT   = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  host_index;
    logic [23:0] rtt_us;
    logic [15:0] reply_seq;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic        probe_ok;
    logic [15:0] probe_seq;
    logic        probes_done;
    logic [1:0]  link_state;
    logic [15:0] tries;
    logic [15:0] replies;
    logic [23:0] min_rtt_us;
    logic [23:0] max_rtt_us;
    logic [23:0] avg_rtt_us;
    logic [23:0] jitter_us;
    logic [6:0]  loss_pct;
    logic [15:0] newest_seq;
  } result_t;

  typedef struct packed {
    item_t  item;
    class_t cls;
  } work_t;

  typedef struct packed {
    logic [15:0] max_probes;
    logic [15:0] down_after_ms;
    logic [15:0] inflight_window_ms;
  } cfg_t;

  typedef struct packed {
    logic [15:0] probe_count;
    logic [15:0] reply_count;
    logic [23:0] rtt_min;
    logic [23:0] rtt_max;
    logic [39:0] rtt_sum;
    logic [23:0] prev_rtt;
    logic        prev_rtt_valid;
    logic [27:0] jitter_acc;
    logic        ever_replied;
    logic [1:0]  host_state;
    logic [15:0] top_seq;
    logic [31:0] probe_time;
    logic [31:0] reply_time;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    probe_count: 16'd0, reply_count: 16'd0, rtt_min: RTT_ONES, rtt_max: 24'd0,
    rtt_sum: 40'd0, prev_rtt: 24'd0, prev_rtt_valid: 1'b0, jitter_acc: 28'd0,
    ever_replied: 1'b0, host_state: LINK_WAIT, top_seq: 16'd0, probe_time: 32'd0,
    reply_time: 32'd0
  };

endpackage

@@ hdl/prh_ram.sv @@
// ----------------------------------------------------------------------------
// prh_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module prh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule

@@ hdl/prh_front.sv @@
// ----------------------------------------------------------------------------
// prh_front
// Input queue: accepts items, classifies them and holds them for the back end.
// ----------------------------------------------------------------------------
module prh_front #(
  parameter int HOSTS = 256
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  prh_pkg::item_t item,
  output logic           full,
  output logic           head_valid,
  output prh_pkg::work_t head,
  input  logic           take
);
  import prh_pkg::*;

  work_t      slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  work_t      w_in;
  logic       do_push;
  logic       do_take;

  always_comb begin
    w_in.item = item;
    if (32'(item.host_index) >= HOSTS) begin
      w_in.cls = CL_OOR;
    end else begin
      case (kind_t'(item.kind))
        KIND_PROBE: w_in.cls = CL_PROBE;
        KIND_REPLY: w_in.cls = CL_REPLY;
        default:    w_in.cls = CL_QUERY;
      endcase
    end
  end

  assign full       = (cnt == 2'd2);
  assign head_valid = (cnt != 2'd0);
  assign head       = slot[rp];
  assign do_push    = push && !full;
  assign do_take    = take && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wp] <= w_in;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= !wp;
      if (do_take) rp <= !rp;
      cnt <= cnt + 2'(do_push) - 2'(do_take);
    end
  end
endmodule

@@ hdl/prh_back.sv @@
// ----------------------------------------------------------------------------
// prh_back
// Sequencer: read-modify-write of one host entry, then serial divisions for
// average and loss, then result hand-off; out-of-table items only hand off.
// ----------------------------------------------------------------------------
module prh_back #(
  parameter int HOSTS        = 256,
  parameter int JITTER_SHIFT = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  prh_pkg::cfg_t    cfg,
  input  logic             head_valid,
  input  prh_pkg::work_t   head,
  output logic             take,
  output prh_pkg::result_t res,
  output logic             empty,
  input  logic             pop
);
  import prh_pkg::*;

  localparam int DEPTH = (HOSTS > 256) ? 256 : HOSTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [28:0] HALF = 29'(1) << (JITTER_SHIFT - 1);

  state_t      st;
  state_t      st_next;
  work_t       cur;
  entry_t      ne;
  entry_t      e;
  entry_t      upd;
  entry_t      rdata;
  result_t     rb;
  logic [DEPTH-1:0] vld;
  logic [AW-1:0]    addr;
  logic        ram_re;
  logic        ram_we;
  logic        load_out;

  logic [15:0] rem_a;
  logic [39:0] q_a;
  logic [15:0] den_a;
  logic [15:0] rem_l;
  logic [39:0] q_l;
  logic [15:0] den_l;
  logic [5:0]  cnt;
  logic        avg_zero;
  logic        loss_zero;

  // update datapath
  logic        allowed;
  logic [15:0] nc;
  logic [40:0] sum_w;
  logic [15:0] dseq;
  logic [23:0] diff;
  logic [28:0] jr;
  logic [28:0] acc_w;
  // report prep
  logic [28:0] jit_w;
  logic        young;
  logic [15:0] eff;
  logic [22:0] lx;
  logic [16:0] ta;
  logic [16:0] tl;

  assign addr = cur.item.host_index[AW-1:0];

  prh_ram #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (addr),
    .wdata (ne),
    .rdata (rdata)
  );

  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE:  if (head_valid) st_next = (head.cls == CL_OOR) ? ST_OUT : ST_READ;
      ST_READ:  st_next = ST_UPD;
      ST_UPD:   st_next = ST_WRITE;
      ST_WRITE: st_next = ST_DIV;
      ST_DIV:   if (cnt == 6'(DIV_STEPS - 1)) st_next = ST_FIN;
      ST_FIN:   st_next = ST_OUT;
      ST_OUT:   if (empty || pop) st_next = ST_IDLE;
      default:  st_next = ST_IDLE;
    endcase
  end

  always_comb begin
    take     = 1'b0;
    ram_re   = 1'b0;
    ram_we   = 1'b0;
    load_out = 1'b0;
    unique case (st)
      ST_IDLE:  take = head_valid;
      ST_READ:  ram_re = 1'b1;
      ST_WRITE: ram_we = 1'b1;
      ST_OUT:   load_out = empty || pop;
      default:  ;
    endcase
  end

  always_comb begin
    e   = vld[addr] ? rdata : ENTRY_RESET;
    upd = e;
    allowed = !(cfg.max_probes != 16'd0 && e.probe_count >= cfg.max_probes);
    nc      = (e.probe_count != 16'hFFFF) ? e.probe_count + 16'd1 : e.probe_count;
    sum_w   = {1'b0, e.rtt_sum} + 41'(cur.item.rtt_us);
    dseq    = cur.item.reply_seq - e.top_seq;
    diff    = (cur.item.rtt_us >= e.prev_rtt) ? cur.item.rtt_us - e.prev_rtt
                                              : e.prev_rtt - cur.item.rtt_us;
    jr      = ({1'b0, e.jitter_acc} + HALF) >> JITTER_SHIFT;
    acc_w   = {1'b0, e.jitter_acc} + 29'(diff) - jr;
    if (cur.cls == CL_PROBE && allowed) begin
      upd.probe_time  = cur.item.now_ms;
      upd.probe_count = nc;
      if (nc > 16'd1 && (!e.ever_replied ||
          (cur.item.now_ms - e.reply_time) >= 32'(cfg.down_after_ms))) begin
        upd.host_state = LINK_DOWN;
      end
    end else if (cur.cls == CL_REPLY) begin
      upd.rtt_sum      = sum_w[40] ? SUM_ONES : sum_w[39:0];
      upd.ever_replied = 1'b1;
      upd.host_state   = LINK_UP;
      upd.reply_time   = cur.item.now_ms;
      if (e.reply_count != 16'hFFFF) upd.reply_count = e.reply_count + 16'd1;
      if ((dseq != 16'd0 && !dseq[15]) || !e.ever_replied) upd.top_seq = cur.item.reply_seq;
      if (cur.item.rtt_us < e.rtt_min) upd.rtt_min = cur.item.rtt_us;
      if (cur.item.rtt_us > e.rtt_max) upd.rtt_max = cur.item.rtt_us;
      if (e.prev_rtt_valid) upd.jitter_acc = acc_w[28] ? JACC_ONES : acc_w[27:0];
      upd.prev_rtt       = cur.item.rtt_us;
      upd.prev_rtt_valid = 1'b1;
    end
  end

  always_comb begin
    jit_w = ({1'b0, ne.jitter_acc} + HALF) >> JITTER_SHIFT;
    young = (cur.item.now_ms - ne.probe_time) < 32'(cfg.inflight_window_ms);
    eff   = ne.probe_count;
    if (eff != 16'd0 && eff > ne.reply_count && young) eff = eff - 16'd1;
    lx = 23'(eff - ne.reply_count);
    ta = {rem_a, q_a[39]};
    tl = {rem_l, q_l[39]};
  end

  always_ff @(posedge clk) begin
    if (st == ST_IDLE && head_valid) begin
      cur <= head;
      rb  <= '{min_rtt_us: RTT_ONES, default: '0};
    end
    if (st == ST_UPD) begin
      ne <= upd;
      rb.probe_ok    <= (cur.cls == CL_PROBE) && allowed;
      rb.probe_seq   <= (cur.cls == CL_PROBE && allowed) ? e.probe_count + 16'd1 : 16'd0;
      rb.probes_done <= (cur.cls == CL_PROBE) && allowed &&
                        cfg.max_probes != 16'd0 && nc == cfg.max_probes;
    end
    if (st == ST_WRITE) begin
      rb.link_state <= ne.host_state;
      rb.tries      <= ne.probe_count;
      rb.replies    <= ne.reply_count;
      rb.min_rtt_us <= ne.rtt_min;
      rb.max_rtt_us <= ne.rtt_max;
      rb.jitter_us  <= (jit_w > 29'(RTT_ONES)) ? RTT_ONES : jit_w[23:0];
      rb.newest_seq <= ne.top_seq;
      avg_zero  <= (ne.reply_count == 16'd0);
      loss_zero <= !(eff > ne.reply_count);
      rem_a <= '0;
      q_a   <= ne.rtt_sum;
      den_a <= ne.reply_count;
      rem_l <= '0;
      q_l   <= 40'((lx << 6) + (lx << 5) + (lx << 2));
      den_l <= eff;
      cnt   <= '0;
    end
    if (st == ST_DIV) begin
      cnt <= cnt + 6'd1;
      if (ta >= {1'b0, den_a}) begin
        rem_a <= 16'(ta - {1'b0, den_a});
        q_a   <= {q_a[38:0], 1'b1};
      end else begin
        rem_a <= ta[15:0];
        q_a   <= {q_a[38:0], 1'b0};
      end
      if (tl >= {1'b0, den_l}) begin
        rem_l <= 16'(tl - {1'b0, den_l});
        q_l   <= {q_l[38:0], 1'b1};
      end else begin
        rem_l <= tl[15:0];
        q_l   <= {q_l[38:0], 1'b0};
      end
    end
    if (st == ST_FIN) begin
      rb.avg_rtt_us <= avg_zero ? 24'd0 : ((q_a > 40'(RTT_ONES)) ? RTT_ONES : q_a[23:0]);
      rb.loss_pct   <= loss_zero ? 7'd0 : q_l[6:0];
    end
    if (load_out) begin
      res <= rb;
    end
    if (rst) begin
      st    <= ST_IDLE;
      vld   <= '0;
      empty <= 1'b1;
    end else begin
      st <= st_next;
      if (ram_we) vld[addr] <= 1'b1;
      if (load_out) empty <= 1'b0;
      else if (pop) empty <= 1'b1;
    end
  end
endmodule

@@ hdl/per_host_rtt_statistics.sv @@
// ----------------------------------------------------------------------------
// per_host_rtt_statistics
// Per-host echo probe statistics table: probe grants, reply statistics,
// jitter, average and loss.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter through push/full as one item_t; results leave through
//   empty/pop as one result_t, one result per item, in order.
//   Registers are written through cfg_valid/cfg_ready (always ready) with
//   cfg_index 0 max_probes, 1 down_after_ms, 2 inflight_window_ms; other
//   indexes are ignored. Write only while the block is idle.
//   A two-entry input queue takes items while the back end works.
//   Each item passes through the back end as entry read, update, write,
//   then 40 steps of two one-bit-per-step dividers, one for average and
//   one for loss. Out-of-table host indexes skip straight to the result.
//   The result register holds one finished item; while it is not popped the
//   back end waits and the input queue fills, then full rises.
//   Reset sets the registers to 10, 2000 and 1000, empties both queues and
//   clears per-entry valid bits, so every host reads as freshly reset at once.
// ----------------------------------------------------------------------------
module per_host_rtt_statistics #(
  parameter int HOSTS        = 256,
  parameter int JITTER_SHIFT = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  prh_pkg::item_t   item,
  output logic             full,
  output logic             empty,
  input  logic             pop,
  output prh_pkg::result_t result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data
);
  import prh_pkg::*;

  cfg_t  cfg;
  logic  head_valid;
  work_t head;
  logic  take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_probes         <= 16'd10;
      cfg.down_after_ms      <= 16'd2000;
      cfg.inflight_window_ms <= 16'd1000;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_MAX_PROBES: cfg.max_probes         <= cfg_data;
        REG_DOWN_AFTER: cfg.down_after_ms      <= cfg_data;
        REG_INFLIGHT:   cfg.inflight_window_ms <= cfg_data;
        default:        ;
      endcase
    end
  end

  prh_front #(.HOSTS(HOSTS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .item       (item),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .take       (take)
  );

  prh_back #(.HOSTS(HOSTS), .JITTER_SHIFT(JITTER_SHIFT)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .take       (take),
    .res        (result),
    .empty      (empty),
    .pop        (pop)
  );

`ifndef SYNTH
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");
  a_loss_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> result.loss_pct <= 7'd100)
    else $error("loss percent out of range");
  a_done_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.probes_done) |-> result.probe_ok)
    else $error("probe limit flagged on refused probe");
  a_min_max: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.replies != 16'd0) |-> result.min_rtt_us <= result.max_rtt_us)
    else $error("min above max with replies");
`endif
endmodule
